@@ hw/rtl/tfsd_pkg.sv @@
package tfsd_pkg;

    localparam int FRAME_LEN      = 16;
    localparam int FRAME_DATA_LEN = FRAME_LEN - 1;
    localparam int IDX_W          = 4;
    localparam int ID_W           = 7;
    localparam int BYTE_W         = 8;

    localparam logic [IDX_W-1:0] LAST_DATA_IDX = IDX_W'(FRAME_DATA_LEN - 1);
    localparam logic [IDX_W-1:0] POS_AUX       = IDX_W'(FRAME_DATA_LEN);
    localparam logic [ID_W-1:0]  NULL_ID       = '0;

    typedef struct packed {
        logic [ID_W-1:0]   source_id;
        logic [BYTE_W-1:0] data_byte;
        logic              stop_seen;
        logic              last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_out_req;

    typedef enum logic [3:0] {
        S_FILL   = 4'b0001,
        S_DECODE = 4'b0010,
        S_FLUSH  = 4'b0100,
        S_HALT   = 4'b1000
    } t_state;

endpackage

@@ hw/rtl/tfsd_if.sv @@
interface tfsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] trace_byte;

    modport source (output valid, output trace_byte, input ready);
    modport sink   (input valid, input trace_byte, output ready);
endinterface

interface tfsd_result_if;
    logic       valid;
    logic       ready;
    logic [6:0] source_id;
    logic [7:0] data_byte;
    logic       stop_seen;
    logic       last;

    modport source (output valid, output source_id, output data_byte,
                    output stop_seen, output last, input ready);
    modport sink   (input valid, input source_id, input data_byte,
                    input stop_seen, input last, output ready);
endinterface

@@ hw/rtl/tfsd_frame_mem.sv @@
module tfsd_frame_mem
    import tfsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic [IDX_W-1:0]  i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [0:FRAME_DATA_LEN-1];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/tfsd_out_stage.sv @@
module tfsd_out_stage
    import tfsd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_out_req      i_req,
    output logic          o_can_move,
    tfsd_result_if.source o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;
    t_result n_res;

    assign o_can_move = !r_valid || o_result.ready;

    always_comb begin
        n_valid = r_valid;
        n_res   = r_res;
        if (i_req.valid) begin
            n_valid = 1'b1;
            n_res   = i_req.res;
        end else if (o_result.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_res <= n_res;
    end

    assign o_result.valid     = r_valid;
    assign o_result.source_id = r_res.source_id;
    assign o_result.data_byte = r_res.data_byte;
    assign o_result.stop_seen = r_res.stop_seen;
    assign o_result.last      = r_res.last;

endmodule

@@ hw/rtl/tfsd_decode.sv @@
module tfsd_decode
    import tfsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    tfsd_byte_if.sink         i_trace,
    output logic              o_mem_we,
    output logic [IDX_W-1:0]  o_mem_waddr,
    output logic [BYTE_W-1:0] o_mem_wdata,
    output logic [IDX_W-1:0]  o_mem_raddr,
    input  logic [BYTE_W-1:0] i_mem_rdata,
    input  logic              i_can_move,
    output t_out_req          o_req
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [BYTE_W-1:0] r_aux, n_aux;
    logic              r_prev_lsb, n_prev_lsb;
    logic [ID_W-1:0]   r_cur_src, n_cur_src;
    logic [ID_W-1:0]   r_prev_src, n_prev_src;
    logic              r_halt, n_halt;
    logic              r_pend_valid, n_pend_valid;
    t_result           r_pend, n_pend;

    logic              accept;
    logic              aux_bit;
    logic              cand_valid;
    t_result           cand;
    logic              is_id;
    logic              is_stop;
    logic [ID_W-1:0]   sel_id;
    logic              advance;

    assign i_trace.ready = (r_state == S_FILL) || (r_state == S_HALT);
    assign accept        = i_trace.valid && i_trace.ready;

    assign o_mem_we    = accept && (r_state == S_FILL) && (r_pos != POS_AUX);
    assign o_mem_waddr = r_pos;
    assign o_mem_wdata = i_trace.trace_byte;

    // decode of the byte at r_idx
    always_comb begin
        aux_bit    = r_aux[r_idx[IDX_W-1:1]];
        cand_valid = 1'b0;
        is_id      = 1'b0;
        is_stop    = 1'b0;
        sel_id     = r_cur_src;
        cand       = '0;
        if (r_idx[0]) begin
            sel_id          = (r_prev_lsb && aux_bit) ? r_prev_src : r_cur_src;
            cand.source_id  = sel_id;
            cand.data_byte  = i_mem_rdata;
            cand_valid      = (sel_id != NULL_ID);
        end else if (i_mem_rdata[0]) begin
            is_id = 1'b1;
            if (i_mem_rdata[BYTE_W-1:1] == NULL_ID) begin
                is_stop        = 1'b1;
                cand_valid     = 1'b1;
                cand.stop_seen = 1'b1;
            end
        end else begin
            cand.source_id = r_cur_src;
            cand.data_byte = {i_mem_rdata[BYTE_W-1:1], aux_bit};
            cand_valid     = (r_cur_src != NULL_ID);
        end
    end

    assign advance = (r_state == S_DECODE) && (!cand_valid || !r_pend_valid || i_can_move);

    always_comb begin
        o_req          = '0;
        o_req.res      = r_pend;
        o_req.res.last = (r_state == S_FLUSH);
        o_req.valid    = r_pend_valid && i_can_move &&
                         (((r_state == S_DECODE) && cand_valid) || (r_state == S_FLUSH));
    end

    always_comb begin
        if (r_state == S_DECODE) begin
            o_mem_raddr = (advance && (r_idx != LAST_DATA_IDX)) ? r_idx + 1'b1 : r_idx;
        end else begin
            o_mem_raddr = '0;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_aux        = r_aux;
        n_prev_lsb   = r_prev_lsb;
        n_cur_src    = r_cur_src;
        n_prev_src   = r_prev_src;
        n_halt       = r_halt;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        unique case (r_state)
            S_FILL: begin
                if (accept) begin
                    if (r_pos == POS_AUX) begin
                        n_aux   = i_trace.trace_byte;
                        n_pos   = '0;
                        n_idx   = '0;
                        n_state = S_DECODE;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            S_DECODE: begin
                if (advance) begin
                    n_prev_lsb = i_mem_rdata[0];
                    if (cand_valid) begin
                        n_pend_valid = 1'b1;
                        n_pend       = cand;
                    end
                    if (is_id && !is_stop) begin
                        n_prev_src = r_cur_src;
                        n_cur_src  = i_mem_rdata[BYTE_W-1:1];
                    end
                    if (is_stop) begin
                        n_halt  = 1'b1;
                        n_state = S_FLUSH;
                    end else if (r_idx == LAST_DATA_IDX) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid || i_can_move) begin
                    n_pend_valid = 1'b0;
                    n_state      = r_halt ? S_HALT : S_FILL;
                end
            end
            S_HALT: begin
                n_state = S_HALT;
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_pos        <= '0;
            r_idx        <= '0;
            r_cur_src    <= '0;
            r_prev_src   <= '0;
            r_halt       <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_idx        <= n_idx;
            r_cur_src    <= n_cur_src;
            r_prev_src   <= n_prev_src;
            r_halt       <= n_halt;
            r_pend_valid <= n_pend_valid;
        end
        r_aux      <= n_aux;
        r_prev_lsb <= n_prev_lsb;
        r_pend     <= n_pend;
    end

endmodule

@@ hw/rtl/trace_frame_source_demux.sv @@
// Trace formatter frame decoder. Trace bytes are taken one per transaction and
// grouped into 16-byte frames; the first 15 are written to a frame buffer at one
// per cycle. The 16th (auxiliary) byte starts a walk of the buffer through its
// single read port, one byte per cycle unless the output stalls, emitting each
// data byte that has a source ID, tagged with it; the final result of a frame
// carries last. No input is taken during the walk or the flush, so a new frame
// is not accepted until the last one has been walked and flushed. A null source
// ID emits one stop result, after which input is accepted and discarded.
module trace_frame_source_demux
    import tfsd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    tfsd_byte_if.sink     i_trace,
    tfsd_result_if.source o_result
);

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;
    logic              can_move;
    t_out_req          out_req;

    tfsd_frame_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tfsd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_trace     (i_trace),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .i_can_move  (can_move),
        .o_req       (out_req)
    );

    tfsd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (out_req),
        .o_can_move (can_move),
        .o_result   (o_result)
    );

endmodule

@@ tb/tfsd_frame_checker.sv @@
`timescale 1ns / 1ps

module tfsd_frame_checker
    import tfsd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    tfsd_byte_if   i_trace,
    tfsd_result_if i_result,
    output int     o_fail_count,
    output int     o_pending
);

    logic [BYTE_W-1:0] frame_buf [FRAME_DATA_LEN];
    logic [IDX_W-1:0]  fill_pos;
    logic [ID_W-1:0]   cur_id;
    logic [ID_W-1:0]   prev_id;
    logic              halted;
    t_result           demuxed_bytes [$];
    t_result           got_res;
    t_result           want_res;
    int                fail_total = 0;

    function automatic t_result make_result(logic [ID_W-1:0] id, logic [BYTE_W-1:0] data,
                                            logic stop);
        t_result r;
        r.source_id = id;
        r.data_byte = data;
        r.stop_seen = stop;
        r.last      = 1'b0;
        return r;
    endfunction

    // Walk the buffered frame once the aux byte is in.
    function automatic void decode_frame(logic [BYTE_W-1:0] aux);
        t_result           frame_res [$];
        logic [BYTE_W-1:0] c;
        logic              aux_bit;
        logic [ID_W-1:0]   id;
        for (int i = 0; i < FRAME_DATA_LEN; i++) begin
            c       = frame_buf[i];
            aux_bit = aux[i / 2];
            if (i % 2 == 1) begin
                if (frame_buf[i - 1][0] && aux_bit) begin
                    if (prev_id != NULL_ID)
                        frame_res.push_back(make_result(prev_id, c, 1'b0));
                end else if (cur_id != NULL_ID) begin
                    frame_res.push_back(make_result(cur_id, c, 1'b0));
                end
            end else if (c[0]) begin
                id = c[7:1];
                if (id == NULL_ID) begin
                    frame_res.push_back(make_result(NULL_ID, '0, 1'b1));
                    halted = 1'b1;
                    break;
                end
                prev_id = cur_id;
                cur_id  = id;
            end else begin
                c[0] = aux_bit;
                if (cur_id != NULL_ID)
                    frame_res.push_back(make_result(cur_id, c, 1'b0));
            end
        end
        if (frame_res.size() > 0)
            frame_res[frame_res.size() - 1].last = 1'b1;
        foreach (frame_res[k])
            demuxed_bytes.push_back(frame_res[k]);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_pos = '0;
            cur_id   = NULL_ID;
            prev_id  = NULL_ID;
            halted   = 1'b0;
            demuxed_bytes.delete();
            o_fail_count <= fail_total;
            o_pending    <= 0;
        end else begin
            if (i_result.valid && i_result.ready) begin
                got_res.source_id = i_result.source_id;
                got_res.data_byte = i_result.data_byte;
                got_res.stop_seen = i_result.stop_seen;
                got_res.last      = i_result.last;
                if (demuxed_bytes.size() == 0) begin
                    $display("%0t: unexpected result id=%0h data=%0h stop=%0b last=%0b",
                             $time, got_res.source_id, got_res.data_byte,
                             got_res.stop_seen, got_res.last);
                    fail_total++;
                end else begin
                    want_res = demuxed_bytes.pop_front();
                    if (got_res.source_id !== want_res.source_id ||
                        got_res.data_byte !== want_res.data_byte ||
                        got_res.stop_seen !== want_res.stop_seen ||
                        got_res.last      !== want_res.last) begin
                        $write("%0t: mismatch expected id=%0h data=%0h stop=%0b last=%0b",
                               $time, want_res.source_id, want_res.data_byte,
                               want_res.stop_seen, want_res.last);
                        $display(", got id=%0h data=%0h stop=%0b last=%0b",
                                 got_res.source_id, got_res.data_byte,
                                 got_res.stop_seen, got_res.last);
                        fail_total++;
                    end
                end
            end
            if (i_trace.valid && i_trace.ready && !halted) begin
                if (fill_pos != POS_AUX) begin
                    frame_buf[fill_pos] = i_trace.trace_byte;
                    fill_pos++;
                end else begin
                    fill_pos = '0;
                    decode_frame(i_trace.trace_byte);
                end
            end
            o_fail_count <= fail_total;
            o_pending    <= demuxed_bytes.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import tfsd_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   no_idle = 1'b0;
    int   bytes_sent = 0;

    logic [BYTE_W-1:0] frame_img [FRAME_LEN];

    tfsd_byte_if   trace_ch ();
    tfsd_result_if result_ch ();

    trace_frame_source_demux i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_trace  (trace_ch),
        .o_result (result_ch)
    );

    tfsd_frame_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_trace      (trace_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sink side stalls.
    initial begin
        int r;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (no_idle) begin
                result_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    result_ch.ready <= 1'b1;
                    repeat ($urandom_range(0, 15)) @(negedge i_clk);
                end else if (r < 92) begin
                    result_ch.ready <= 1'b0;
                    repeat ($urandom_range(0, 2)) @(negedge i_clk);
                end else begin
                    result_ch.ready <= 1'b0;
                    repeat ($urandom_range(15, 50)) @(negedge i_clk);
                end
            end
        end
    end

    // Called at a falling edge; returns at a falling edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            trace_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        trace_ch.valid      <= 1'b1;
        trace_ch.trace_byte <= b;
        do @(posedge i_clk); while (!trace_ch.ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < FRAME_LEN; i++)
            send_byte(frame_img[i]);
    endtask

    function automatic void make_random_frame();
        logic [ID_W-1:0] id;
        if ($urandom_range(0, 4) == 0) begin
            // raw noise, null ID kept out
            for (int i = 0; i < FRAME_LEN; i++) begin
                frame_img[i] = 8'($urandom_range(0, 255));
                if (i % 2 == 0 && frame_img[i] == 8'h01)
                    frame_img[i] = 8'h03;
            end
        end else begin
            for (int i = 0; i < FRAME_LEN; i++) begin
                if (i % 2 == 1 || i == FRAME_LEN - 1) begin
                    frame_img[i] = 8'($urandom_range(0, 255));
                end else if ($urandom_range(0, 2) == 0) begin
                    id = ($urandom_range(0, 7) == 0) ? 7'h7f : 7'($urandom_range(1, 127));
                    frame_img[i] = {id, 1'b1};
                end else begin
                    frame_img[i] = {7'($urandom_range(0, 127)), 1'b0};
                end
            end
        end
    endfunction

    initial begin : stimulus
        int stop_pos;
        trace_ch.valid      = 1'b0;
        trace_ch.trace_byte = '0;
        i_rst_n             = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // data before any ID: nothing comes out
        frame_img = '{8'h00, 8'hff, 8'hfe, 8'h00, 8'h80, 8'h7f, 8'h02, 8'h55,
                      8'h40, 8'haa, 8'h10, 8'h01, 8'h20, 8'h80, 8'h04, 8'hff};
        send_frame();
        // ID 0x7f, previous-ID odd bytes, ID in last slot
        frame_img = '{8'hff, 8'h11, 8'hfe, 8'h00, 8'h03, 8'h5a, 8'h05, 8'ha5,
                      8'h00, 8'hff, 8'h81, 8'h3c, 8'h80, 8'h01, 8'hab, 8'ha7};
        send_frame();

        while (bytes_sent < 112) begin
            no_idle = ($urandom_range(0, 5) == 0);
            make_random_frame();
            send_frame();
        end
        no_idle = 1'b0;

        // null ID ends the trace
        make_random_frame();
        stop_pos = 2 * $urandom_range(1, 7);
        frame_img[stop_pos] = 8'h01;
        for (int i = 0; i < stop_pos; i += 2)
            if (frame_img[i] == 8'h01)
                frame_img[i] = 8'h03;
        send_frame();

        // discarded after halt
        for (int i = 0; i < 20; i++)
            send_byte((i % 4 == 0) ? 8'h01 : 8'($urandom_range(0, 255)));
        trace_ch.valid <= 1'b0;

        for (int k = 0; k < 20000 && pending != 0; k++)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/tfsd_pkg.sv
hw/rtl/tfsd_if.sv
hw/rtl/tfsd_frame_mem.sv
hw/rtl/tfsd_out_stage.sv
hw/rtl/tfsd_decode.sv
hw/rtl/trace_frame_source_demux.sv
tb/tfsd_frame_checker.sv
tb/testbench.sv
